>>> rtl/rctt_pkg.sv
// ----------------------------------------------------------------------------
// rctt_pkg: shared types and constants
// Op and result codes, the queued command record and store addressing.
// ----------------------------------------------------------------------------
package rctt_pkg;

	localparam int MAX_TRACKED_DEF  = 15;
	localparam int NUM_CHANNELS_DEF = 8;
	localparam int NUM_PORTS_DEF    = 16;
	localparam int CH_SHIFT         = 5;
	localparam int AGE_WINDOW_RST   = 16;

	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_AGE   = 3'd1;
	localparam logic [2:0] OP_REPORT = 3'd2;
	localparam logic [2:0] OP_CLEAR = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_ENTRY  = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;

	localparam logic [1:0] ST_RESET    = 2'd0;
	localparam logic [1:0] ST_APPENDED = 2'd1;
	localparam logic [1:0] ST_REPLACED = 2'd2;
	localparam logic [1:0] ST_DROPPED  = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  target_id;
		logic [31:0] volt_bits;
		logic        refresh;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [7:0]  entry_id;
		logic [31:0] entry_volts;
		logic [7:0]  entry_age;
		logic        last;
	} res_t;

endpackage

>>> rtl/rctt_if.sv
// ----------------------------------------------------------------------------
// rctt_in_if / rctt_out_if: valid-ready channels
// Input item channel and result item channel.
// ----------------------------------------------------------------------------
interface rctt_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [7:0]  target_id;
	logic [31:0] volt_bits;
	logic        refresh;
	modport source (output valid, op, target_id, volt_bits, refresh, input ready);
	modport sink   (input valid, op, target_id, volt_bits, refresh, output ready);
endinterface

interface rctt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  status;
	logic [7:0]  entry_id;
	logic [31:0] entry_volts;
	logic [7:0]  entry_age;
	logic        last;
	modport source (output valid, kind, status, entry_id, entry_volts, entry_age, last,
		input ready);
	modport sink   (input valid, kind, status, entry_id, entry_volts, entry_age, last,
		output ready);
endinterface

>>> rtl/recent_change_tracker_table_top.sv
// ----------------------------------------------------------------------------
// recent_change_tracker_table_top: recent change tracker table
// Ordered table of recently changed identifiers with a voltage store.
// ----------------------------------------------------------------------------
// Items enter a two-deep command queue and a sequencer carries them out one at
// a time, walking the table entry by entry. A store write or clear is done
// straight from the queue; a report searches, then fills or drops; an aging
// pass reads each entry and writes back the kept ones (the store read for a
// refresh is registered); a read out gives one result per cycle while the
// output is taken.
module recent_change_tracker_table_top #(
	parameter int MAX_TRACKED  = rctt_pkg::MAX_TRACKED_DEF,
	parameter int NUM_CHANNELS = rctt_pkg::NUM_CHANNELS_DEF,
	parameter int NUM_PORTS    = rctt_pkg::NUM_PORTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	rctt_in_if.sink     in_ch,
	rctt_out_if.source  out_ch
);
	import rctt_pkg::*;

	logic [6:0] age_window_q;
	logic       cmd_valid, cmd_pop;
	cmd_t       cmd;

	// hold the aging window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) age_window_q <= 7'(AGE_WINDOW_RST);
		else if (cfg_we) age_window_q <= cfg_wdata;
	end

	rctt_front u_front (
		.clk, .arst_n, .in_ch,
		.cmd_valid, .cmd, .cmd_pop
	);

	rctt_back #(
		.MAX_TRACKED(MAX_TRACKED), .NUM_CHANNELS(NUM_CHANNELS), .NUM_PORTS(NUM_PORTS)
	) u_back (
		.clk, .arst_n, .age_window(age_window_q),
		.cmd_valid, .cmd, .cmd_pop, .out_ch
	);
endmodule

>>> rtl/rctt_front.sv
// ----------------------------------------------------------------------------
// rctt_front: command queue
// Accept items, drop unknown ops, and queue the rest for the back end.
// ----------------------------------------------------------------------------
module rctt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	rctt_in_if.sink              in_ch,
	output logic                 cmd_valid,
	output rctt_pkg::cmd_t       cmd,
	input  logic                 cmd_pop
);
	import rctt_pkg::*;

	localparam int DEPTH = 2;

	cmd_t       fifo_q [DEPTH];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       in_cmd;

	assign in_ch.ready = (cnt_q != 2'(DEPTH));
	assign in_cmd = '{op: in_ch.op, target_id: in_ch.target_id,
		volt_bits: in_ch.volt_bits, refresh: in_ch.refresh};
	// unknown ops have no effect: never queue them
	assign push = in_ch.valid && in_ch.ready && (in_ch.op <= OP_READ);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule

>>> rtl/rctt_back.sv
// ----------------------------------------------------------------------------
// rctt_back: table sequencer
// Walk the table entry by entry to carry out queued commands.
// ----------------------------------------------------------------------------
module rctt_back #(
	parameter int MAX_TRACKED  = rctt_pkg::MAX_TRACKED_DEF,
	parameter int NUM_CHANNELS = rctt_pkg::NUM_CHANNELS_DEF,
	parameter int NUM_PORTS    = rctt_pkg::NUM_PORTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [6:0]     age_window,
	input  logic           cmd_valid,
	input  rctt_pkg::cmd_t cmd,
	output logic           cmd_pop,
	rctt_out_if.source     out_ch
);
	import rctt_pkg::*;

	localparam int IW = $clog2(MAX_TRACKED + 1);
	localparam int XW = (MAX_TRACKED > 1) ? $clog2(MAX_TRACKED) : 1;
	localparam int WORDS = NUM_CHANNELS * NUM_PORTS;
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_AGE  = 3'd1; // read entry i, store word issued
	localparam logic [2:0] S_AGEW = 3'd2; // write kept entry
	localparam logic [2:0] S_SRCH = 3'd3;
	localparam logic [2:0] S_FILL = 3'd4; // store data ready, write entry
	localparam logic [2:0] S_READ = 3'd5;
	localparam logic [2:0] S_WAIT = 3'd6;

	logic [2:0]   state_q;
	logic [IW-1:0] i_q, n_q, cnt_q;
	logic [IW-1:0] hit_q, stale_q;
	logic          hit_f_q, stale_f_q;
	logic [1:0]    fill_st_q;
	cmd_t          c_q;
	logic [7:0]    ids_q   [MAX_TRACKED];
	logic [7:0]    ages_q  [MAX_TRACKED];
	logic [31:0]   volts_q [MAX_TRACKED];
	logic [31:0]   store_q [WORDS];
	logic [WORDS-1:0] sval_q;
	logic [31:0]   srd_q;
	logic          sok_q, sval_rd_q;
	logic [7:0]    eid_q, eage_q;
	logic [31:0]   evolt_q;
	logic [XW-1:0] wi_q;
	res_t          res_q;
	logic          ovalid_q;

	logic [XW-1:0] ix;
	logic [7:0]    rid;
	logic [AW-1:0] a_rd, a_wr;
	logic          ok_rd, ok_wr;
	logic [31:0]   sdata;
	logic          out_free;
	logic          srch_end, drop_now, out_set;

	function automatic logic addr_ok(input logic [7:0] id);
		return (int'(id[7:CH_SHIFT]) < NUM_CHANNELS) && (int'(id[3:0]) < NUM_PORTS);
	endfunction
	function automatic logic [AW-1:0] addr_of(input logic [7:0] id);
		return AW'(int'(id[7:CH_SHIFT]) * NUM_PORTS + int'(id[3:0]));
	endfunction

	assign ix  = i_q[XW-1:0];
	// a report reads the store word of its own id while the search runs
	assign rid = (state_q == S_IDLE) ? cmd.target_id :
		(state_q == S_SRCH) ? c_q.target_id : ids_q[ix];
	assign a_rd = addr_of(rid);
	assign ok_rd = addr_ok(rid);
	assign a_wr = addr_of(cmd.target_id);
	assign ok_wr = addr_ok(cmd.target_id);
	assign sdata = (sok_q && sval_rd_q) ? srd_q : 32'd0;
	assign out_free = !ovalid_q || out_ch.ready;

	assign srch_end = (state_q == S_SRCH) && !(i_q != cnt_q && !hit_f_q) && out_free;
	assign drop_now = srch_end && !hit_f_q && !(int'(cnt_q) < MAX_TRACKED) && !stale_f_q;
	assign out_set  = drop_now || (state_q == S_FILL) || (state_q == S_READ && out_free);

	assign out_ch.valid       = ovalid_q;
	assign out_ch.kind        = res_q.kind;
	assign out_ch.status      = res_q.status;
	assign out_ch.entry_id    = res_q.entry_id;
	assign out_ch.entry_volts = res_q.entry_volts;
	assign out_ch.entry_age   = res_q.entry_age;
	assign out_ch.last        = res_q.last;

	// store: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid && cmd.op == OP_WRITE && ok_wr)
			store_q[a_wr] <= cmd.volt_bits;
		srd_q <= store_q[a_rd];
		sok_q <= ok_rd;
	end

	// short ops pop at once, long ops pop on their way out through S_WAIT
	assign cmd_pop = (state_q == S_WAIT) || ((state_q == S_IDLE) && cmd_valid &&
		(cmd.op == OP_WRITE || cmd.op == OP_CLEAR));

	always_ff @(posedge clk) begin
		if (state_q == S_AGEW) begin
			ids_q[n_q[XW-1:0]]   <= eid_q;
			ages_q[n_q[XW-1:0]]  <= eage_q + 8'd1;
			volts_q[n_q[XW-1:0]] <= c_q.refresh ? sdata : evolt_q;
		end else if (state_q == S_FILL) begin
			ids_q[wi_q] <= c_q.target_id;
			ages_q[wi_q] <= 8'd0;
			if (!hit_f_q) volts_q[wi_q] <= sdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			i_q      <= '0;
			n_q      <= '0;
			ovalid_q <= 1'b0;
			sval_q   <= '0;
			sval_rd_q <= 1'b0;
			hit_f_q  <= 1'b0;
			stale_f_q <= 1'b0;
		end else begin
			sval_rd_q <= sval_q[a_rd];
			ovalid_q <= out_set || (ovalid_q && !out_ch.ready);
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						c_q <= cmd;
						i_q <= '0;
						n_q <= '0;
						hit_f_q <= 1'b0;
						stale_f_q <= 1'b0;
						case (cmd.op)
							OP_WRITE: if (ok_wr) sval_q[a_wr] <= 1'b1;
							OP_CLEAR: cnt_q <= '0;
							OP_AGE:   state_q <= (cnt_q == '0) ? S_WAIT : S_AGE;
							OP_REPORT: state_q <= S_SRCH;
							OP_READ:  state_q <= S_READ;
							default: ;
						endcase
					end
				end
				S_AGE: begin
					eid_q <= ids_q[ix];
					eage_q <= ages_q[ix];
					evolt_q <= volts_q[ix];
					if ({1'b0, ages_q[ix]} >= {1'b0, age_window, 1'b0}) begin
						if (i_q + 1'b1 == cnt_q) begin
							cnt_q <= n_q;
							state_q <= S_WAIT;
						end
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= S_AGEW;
					end
				end
				S_AGEW: begin
					n_q <= n_q + 1'b1;
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == cnt_q) begin
						cnt_q <= n_q + 1'b1;
						state_q <= S_WAIT;
					end else begin
						state_q <= S_AGE;
					end
				end
				S_SRCH: begin
					// one entry a cycle: note match and newest stale entry
					if (i_q != cnt_q && !hit_f_q) begin
						if (ids_q[ix] == c_q.target_id) begin
							hit_f_q <= 1'b1;
							hit_q <= i_q;
						end
						if (ages_q[ix] > {1'b0, age_window}) begin
							stale_f_q <= 1'b1;
							stale_q <= i_q;
						end
						i_q <= i_q + 1'b1;
					end else if (out_free) begin
						if (hit_f_q) begin
							wi_q <= hit_q[XW-1:0];
							fill_st_q <= ST_RESET;
							state_q <= S_FILL;
						end else if (int'(cnt_q) < MAX_TRACKED) begin
							wi_q <= cnt_q[XW-1:0];
							cnt_q <= cnt_q + 1'b1;
							fill_st_q <= ST_APPENDED;
							state_q <= S_FILL;
						end else if (stale_f_q) begin
							wi_q <= stale_q[XW-1:0];
							fill_st_q <= ST_REPLACED;
							state_q <= S_FILL;
						end else begin
							res_q <= '{kind: KIND_STATUS, status: ST_DROPPED,
								entry_id: c_q.target_id, entry_volts: 32'd0,
								entry_age: 8'd0, last: 1'b1};
							state_q <= S_WAIT;
						end
					end
				end
				S_FILL: begin
					// the store read of target_id has settled
					res_q <= '{kind: KIND_STATUS, status: fill_st_q,
						entry_id: c_q.target_id,
						entry_volts: hit_f_q ? volts_q[wi_q] : sdata,
						entry_age: 8'd0, last: 1'b1};
					state_q <= S_WAIT;
				end
				S_READ: begin
					if (out_free) begin
						if (cnt_q == '0) begin
							res_q <= '{kind: KIND_EMPTY, status: ST_RESET, entry_id: 8'd0,
								entry_volts: 32'd0, entry_age: 8'd0, last: 1'b1};
							state_q <= S_WAIT;
						end else begin
							res_q <= '{kind: KIND_ENTRY, status: ST_RESET,
								entry_id: ids_q[ix], entry_volts: volts_q[ix],
								entry_age: ages_q[ix], last: (i_q + 1'b1 == cnt_q)};
							i_q <= i_q + 1'b1;
							if (i_q + 1'b1 == cnt_q) state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> verif/rctt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rctt_checker: result checker for the recent change tracker table
// Watches the config port and both channels, keeps its own copy of the table,
// the voltage store and the window, and compares every result item in order.
// ----------------------------------------------------------------------------
module rctt_checker
	import rctt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	rctt_in_if         in_ch,
	rctt_out_if        out_ch,
	output int         fail_count,
	output int         pending
);

	logic [7:0]  tbl_id   [MAX_TRACKED_DEF];
	logic [7:0]  tbl_age  [MAX_TRACKED_DEF];
	logic [31:0] tbl_volt [MAX_TRACKED_DEF];
	int          tbl_count;
	logic [31:0] volt_mem [NUM_CHANNELS_DEF * NUM_PORTS_DEF];
	logic [6:0]  window;
	res_t        awaited_results[$];

	// channel is bits 7..5, port bits 3..0; bit 4 does not take part
	function automatic logic [31:0] store_word(logic [7:0] id);
		return volt_mem[{id[7:CH_SHIFT], id[3:0]}];
	endfunction

	function automatic res_t make_res(logic [1:0] kind, logic [1:0] st, logic [7:0] id,
		logic [31:0] volts, logic [7:0] age, logic last);
		res_t r;
		r.kind        = kind;
		r.status      = st;
		r.entry_id    = id;
		r.entry_volts = volts;
		r.entry_age   = age;
		r.last        = last;
		return r;
	endfunction

	task automatic apply_item(cmd_t c);
		int n;
		int hit;
		hit = -1;
		case (c.op)
			OP_WRITE: begin
				volt_mem[{c.target_id[7:CH_SHIFT], c.target_id[3:0]}] = c.volt_bits;
			end
			OP_AGE: begin
				n = 0;
				for (int i = 0; i < tbl_count; i++) begin
					if ({1'b0, tbl_age[i]} >= 9'(2 * window))
						continue;
					tbl_id[n]   = tbl_id[i];
					tbl_volt[n] = c.refresh ? store_word(tbl_id[i]) : tbl_volt[i];
					tbl_age[n]  = tbl_age[i] + 8'd1;
					n++;
				end
				tbl_count = n;
			end
			OP_REPORT: begin
				for (int i = 0; i < tbl_count && hit < 0; i++)
					if (tbl_id[i] == c.target_id)
						hit = i;
				if (hit >= 0) begin
					tbl_age[hit] = 8'd0;
					awaited_results.push_back(make_res(KIND_STATUS, ST_RESET, c.target_id,
						tbl_volt[hit], 8'd0, 1'b1));
				end else if (tbl_count < MAX_TRACKED_DEF) begin
					tbl_id[tbl_count]   = c.target_id;
					tbl_age[tbl_count]  = 8'd0;
					tbl_volt[tbl_count] = store_word(c.target_id);
					awaited_results.push_back(make_res(KIND_STATUS, ST_APPENDED, c.target_id,
						tbl_volt[tbl_count], 8'd0, 1'b1));
					tbl_count++;
				end else begin
					// newest stale entry wins the slot
					for (int i = MAX_TRACKED_DEF - 1; i >= 0 && hit < 0; i--)
						if (tbl_age[i] > {1'b0, window})
							hit = i;
					if (hit >= 0) begin
						tbl_id[hit]   = c.target_id;
						tbl_age[hit]  = 8'd0;
						tbl_volt[hit] = store_word(c.target_id);
						awaited_results.push_back(make_res(KIND_STATUS, ST_REPLACED,
							c.target_id, tbl_volt[hit], 8'd0, 1'b1));
					end else begin
						awaited_results.push_back(make_res(KIND_STATUS, ST_DROPPED,
							c.target_id, 32'd0, 8'd0, 1'b1));
					end
				end
			end
			OP_CLEAR: begin
				tbl_count = 0;
			end
			OP_READ: begin
				if (tbl_count == 0)
					awaited_results.push_back(make_res(KIND_EMPTY, ST_RESET, 8'd0, 32'd0,
						8'd0, 1'b1));
				for (int i = 0; i < tbl_count; i++)
					awaited_results.push_back(make_res(KIND_ENTRY, ST_RESET, tbl_id[i],
						tbl_volt[i], tbl_age[i], i == tbl_count - 1));
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		$display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
		fail_count++;
	endtask

	task automatic compare_result(res_t got);
		res_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: result item with nothing expected", $realtime);
			fail_count++;
			return;
		end
		want = awaited_results.pop_front();
		if (got.kind != want.kind)               report_mismatch("kind", want.kind, got.kind);
		if (got.status != want.status)           report_mismatch("status", want.status, got.status);
		if (got.entry_id != want.entry_id)       report_mismatch("entry_id", want.entry_id, got.entry_id);
		if (got.entry_volts !== want.entry_volts)
			report_mismatch("entry_volts", want.entry_volts, got.entry_volts);
		if (got.entry_age != want.entry_age)     report_mismatch("entry_age", want.entry_age, got.entry_age);
		if (got.last != want.last)               report_mismatch("last", want.last, got.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count = 0;
			tbl_count = 0;
			window = 7'(AGE_WINDOW_RST);
			foreach (volt_mem[i]) volt_mem[i] = 32'd0;
			awaited_results.delete();
		end else begin
			if (out_ch.valid && out_ch.ready)
				compare_result(make_res(out_ch.kind, out_ch.status, out_ch.entry_id,
					out_ch.entry_volts, out_ch.entry_age, out_ch.last));
			if (cfg_we)
				window = cfg_wdata;
			if (in_ch.valid && in_ch.ready)
				apply_item('{op: in_ch.op, target_id: in_ch.target_id,
					volt_bits: in_ch.volt_bits, refresh: in_ch.refresh});
		end
		pending = awaited_results.size();
	end

endmodule

>>> verif/recent_change_tracker_table_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recent_change_tracker_table_top_test: testbench top
// Drives directed and random item sequences with random gaps and output
// stalls over several aging windows; the checker judges every result item.
// ----------------------------------------------------------------------------
module recent_change_tracker_table_top_test;
	import rctt_pkg::*;

	// worst case in the block: one item with a 2-deep queue ahead of it
	localparam int DRAIN_CYCLES = 100;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;
	int         fail_count;
	int         pending;
	bit         calm;        // no idling on either side while set
	logic [7:0] id_pool[16]; // small id set so reports hit existing entries

	rctt_in_if  in_ch();
	rctt_out_if out_ch();

	recent_change_tracker_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	rctt_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond every item waiting out long stalls on all results.
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if (calm)
			return 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 0;
			5, 6, 7:       return $urandom_range(1, 3);
			8:             return $urandom_range(4, 10);
			default:       return $urandom_range(15, 40);
		endcase
	endfunction

	// Result side: hold ready low for random stretches, draw again when done.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else begin
			stall_left = pick_gap();
			out_ch.ready <= (stall_left == 0);
		end
	end

	// Present one item and hold it until the block takes it. Valid stays high
	// across back-to-back items so it is never lowered and raised in one step.
	task automatic send_item(logic [2:0] op, logic [7:0] id, logic [31:0] volts, logic refresh);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.op        <= op;
		in_ch.target_id <= id;
		in_ch.volt_bits <= volts;
		in_ch.refresh   <= refresh;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Drop valid, let every expected result out and the sequencer settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Change the window only with the block idle.
	task automatic set_window(logic [6:0] w);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_item();
		logic [7:0] id;
		id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : id_pool[$urandom_range(0, 15)];
		case ($urandom_range(0, 99)) inside
			[0:39]:  send_item(OP_REPORT, id, $urandom, 1'($urandom));
			[40:59]: send_item(OP_AGE, id, $urandom, 1'($urandom));
			[60:74]: send_item(OP_WRITE, id, $urandom, 1'($urandom));
			[75:88]: send_item(OP_READ, id, $urandom, 1'($urandom));
			[89:92]: send_item(OP_CLEAR, id, $urandom, 1'($urandom));
			default: send_item(3'($urandom_range(5, 7)), id, $urandom, 1'($urandom));
		endcase
	endtask

	initial begin
		logic [6:0] windows[8];
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		calm            = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.op        = OP_WRITE;
		in_ch.target_id = '0;
		in_ch.volt_bits = '0;
		in_ch.refresh   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty read out, store extremes, append and age reset.
		send_item(OP_READ, 8'h00, 32'h0, 1'b0);
		send_item(OP_WRITE, 8'h00, 32'hFFFF_FFFF, 1'b0);
		send_item(OP_WRITE, 8'hFF, 32'h0000_0001, 1'b1);
		send_item(OP_WRITE, 8'hEF, 32'h8000_0000, 1'b0); // bit 4 aliases 8'hFF
		send_item(OP_REPORT, 8'h00, 32'h0, 1'b0);
		send_item(OP_REPORT, 8'hFF, 32'h0, 1'b0);
		send_item(OP_REPORT, 8'h00, 32'h0, 1'b0);
		send_item(OP_AGE, 8'h00, 32'h0, 1'b0);
		send_item(OP_WRITE, 8'h00, 32'h3F80_0000, 1'b0);
		send_item(OP_AGE, 8'h00, 32'h0, 1'b1);
		send_item(OP_READ, 8'h00, 32'h0, 1'b0);
		send_item(3'd5, 8'h12, 32'h0, 1'b0);
		send_item(3'd7, 8'h34, 32'h0, 1'b1);
		send_item(OP_CLEAR, 8'h00, 32'h0, 1'b0);
		send_item(OP_READ, 8'h00, 32'h0, 1'b0);

		// Directed: fill the table, drop a report, age past a window of 2,
		// then replace the newest stale entries.
		set_window(7'd2);
		for (int i = 0; i < MAX_TRACKED_DEF; i++)
			send_item(OP_REPORT, 8'(i * 17), 32'h0, 1'b0);
		send_item(OP_REPORT, 8'hAB, 32'h0, 1'b0);
		repeat (3) send_item(OP_AGE, 8'h00, 32'h0, 1'b1);
		send_item(OP_REPORT, 8'hAB, 32'h0, 1'b0);
		send_item(OP_REPORT, 8'hCD, 32'h0, 1'b0);
		send_item(OP_READ, 8'h00, 32'h0, 1'b0);
		send_item(OP_AGE, 8'h00, 32'h0, 1'b0);
		send_item(OP_READ, 8'h00, 32'h0, 1'b0);

		// Random phases, one window each; extremes included.
		windows = '{7'd0, 7'd127, 7'd1, 7'd3, 7'd16, 7'd2, 7'd5, 7'($urandom_range(1, 127))};
		foreach (windows[p]) begin
			set_window(windows[p]);
			calm = (p % 3 == 2);
			foreach (id_pool[i]) id_pool[i] = 8'($urandom);
			repeat (44) random_item();
		end
		calm = 1'b0;

		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
